@@ rtl/mexp_pkg.sv @@
// ----------------------------------------------------------------------------
// mexp_pkg
// shared types and codes for the modular exponentiation block
// ----------------------------------------------------------------------------
package mexp_pkg;

    localparam logic MM_MUL = 1'b0;
    localparam logic MM_RED = 1'b1;

    typedef struct packed {
        logic start;
        logic mode;
    } t_mm_ctrl;

endpackage

@@ rtl/mexp_mulmod.sv @@
// ----------------------------------------------------------------------------
// mexp_mulmod
// bit-serial modular multiply / reduce unit, one multiplier bit per cycle
// ----------------------------------------------------------------------------
module mexp_mulmod import mexp_pkg::*; #(
    parameter int W = 31
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_mm_ctrl     i_ctrl,
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_b,
    input  logic [W-1:0] i_m,
    output logic         o_done,
    output logic [W-1:0] o_res
);

    localparam int CW = $clog2(W + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic          r_mode;
    logic [W-1:0]  r_acc;
    logic [W-1:0]  r_mult;
    logic [W-1:0]  r_a;
    logic [W-1:0]  r_m;

    logic [W+1:0]  addend;
    logic [W+1:0]  sum;
    logic [W+1:0]  m1;
    logic [W+1:0]  m2;
    logic [W+1:0]  red;
    logic [W-1:0]  n_acc;

    // acc = (2*acc + addend) mod m, sum stays below 3m
    always_comb begin
        if (r_mode == MM_RED) begin
            addend = {{(W+1){1'b0}}, r_mult[W-1]};
        end else begin
            addend = r_mult[W-1] ? {2'b00, r_a} : '0;
        end
        sum = {1'b0, r_acc, 1'b0} + addend;
        m1  = {2'b00, r_m};
        m2  = {1'b0, r_m, 1'b0};
        if (sum >= m2) begin
            red = sum - m2;
        end else if (sum >= m1) begin
            red = sum - m1;
        end else begin
            red = sum;
        end
        n_acc = red[W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctrl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.start) begin
            r_acc  <= '0;
            r_mult <= i_b;
            r_a    <= i_a;
            r_m    <= i_m;
            r_mode <= i_ctrl.mode;
        end else if (r_busy) begin
            r_acc  <= n_acc;
            r_mult <= {r_mult[W-2:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_res  = r_acc;

`ifndef SYNTHESIS
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.start |-> !r_busy)
        else $error("mulmod started while busy");
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("mulmod done without work");
    a_res_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_acc < r_m))
        else $error("mulmod result not reduced");
`endif

endmodule

@@ rtl/modular_exponentiation.sv @@
// ----------------------------------------------------------------------------
// modular_exponentiation
// base^exponent mod modulus by right-to-left square-and-multiply
// ----------------------------------------------------------------------------
// One word is taken at a time. The base is first reduced on the single
// bit-serial multiply unit. Every exponent bit below the highest set one then
// costs one squaring, and a set bit also costs one multiply; a squaring right
// after a multiply is started as the multiply finishes, without going back to
// the bit-scan state. A zero exponent gives 1; with a nonzero exponent, a
// modulus of 0 or 1 gives 0, both without using the multiply unit. The input is
// ready again as soon as the result sits in the output register.
module modular_exponentiation import mexp_pkg::*; #(
    parameter int OPERAND_BITS = 31
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [OPERAND_BITS-1:0] i_base,
    input  logic [OPERAND_BITS-1:0] i_exponent,
    input  logic [OPERAND_BITS-1:0] i_modulus,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [OPERAND_BITS-1:0] o_result
);

    localparam int W = OPERAND_BITS;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RED  = 3'd1;
    localparam logic [2:0] S_BIT  = 3'd2;
    localparam logic [2:0] S_MACC = 3'd3;
    localparam logic [2:0] S_MSQ  = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    logic [2:0]   r_state;
    logic [2:0]   n_state;
    logic [W-1:0] r_exp;
    logic [W-1:0] n_exp;
    logic [W-1:0] r_m;
    logic [W-1:0] n_m;
    logic [W-1:0] r_acc;
    logic [W-1:0] n_acc;
    logic [W-1:0] r_sq;
    logic [W-1:0] n_sq;
    logic         r_out_valid;
    logic [W-1:0] r_out;

    t_mm_ctrl     mm_ctrl;
    logic [W-1:0] mm_a;
    logic [W-1:0] mm_b;
    logic [W-1:0] mm_m;
    logic         mm_done;
    logic [W-1:0] mm_res;
    logic         in_acc;

    assign in_acc = i_in_valid && o_in_ready;

    always_comb begin
        n_state      = r_state;
        n_exp        = r_exp;
        n_m          = r_m;
        n_acc        = r_acc;
        n_sq         = r_sq;
        mm_ctrl      = '0;
        mm_ctrl.mode = MM_MUL;
        mm_a         = r_sq;
        mm_b         = r_sq;
        mm_m         = r_m;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_exp = i_exponent;
                    n_m   = i_modulus;
                    if (i_exponent == '0) begin
                        n_acc   = W'(1);
                        n_state = S_FIN;
                    end else if (i_modulus <= W'(1)) begin
                        n_acc   = '0;
                        n_state = S_FIN;
                    end else begin
                        n_acc         = W'(1);
                        mm_ctrl.start = 1'b1;
                        mm_ctrl.mode  = MM_RED;
                        mm_b          = i_base;
                        mm_m          = i_modulus;
                        n_state       = S_RED;
                    end
                end
            end
            S_RED: begin
                if (mm_done) begin
                    n_sq    = mm_res;
                    n_state = S_BIT;
                end
            end
            S_BIT: begin
                mm_ctrl.start = 1'b1;
                if (r_exp[0]) begin
                    mm_a    = r_acc;
                    n_state = S_MACC;
                end else begin
                    n_state = S_MSQ;
                end
            end
            S_MACC: begin
                if (mm_done) begin
                    n_acc = mm_res;
                    if (r_exp[W-1:1] == '0) begin
                        n_state = S_FIN;
                    end else begin
                        mm_ctrl.start = 1'b1;
                        n_state       = S_MSQ;
                    end
                end
            end
            S_MSQ: begin
                if (mm_done) begin
                    n_sq    = mm_res;
                    n_exp   = {1'b0, r_exp[W-1:1]};
                    n_state = S_BIT;
                end
            end
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_FIN && (!r_out_valid || i_out_ready)) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_exp <= n_exp;
        r_m   <= n_m;
        r_acc <= n_acc;
        r_sq  <= n_sq;
        if (r_state == S_FIN && (!r_out_valid || i_out_ready)) begin
            r_out <= r_acc;
        end
    end

    mexp_mulmod #(
        .W (W)
    ) u_mulmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (mm_ctrl),
        .i_a     (mm_a),
        .i_b     (mm_b),
        .i_m     (mm_m),
        .o_done  (mm_done),
        .o_res   (mm_res)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

`ifndef SYNTHESIS
    a_bit_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BIT) |-> (r_exp != '0))
        else $error("exponent scan with no bits left");
    a_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mm_done |-> (r_state == S_RED || r_state == S_MACC || r_state == S_MSQ))
        else $error("multiply unit done in wrong state");
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state != S_IDLE))
        else $error("accepted word did not start work");
`endif

endmodule
